// File: hdl/ofa_pkg.sv
// Shared constants and types for the orthonormal frame pipeline.
// No dependencies; imported by the top level.
package ofa_pkg;

	localparam int DEFAULT_COMPONENT_WIDTH = 24;

	// Q1.30 result format
	localparam int FRAC_BITS = 30;
	localparam int QUOT_BITS = 31;
	localparam int OUT_W     = 32;
	localparam logic [OUT_W-1:0] ONE_Q30 = 32'h4000_0000;

	// register file
	localparam int MIN_NORM_W = 48;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 4;
	localparam logic REG_MIN_NORM = 1'b0;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

endpackage

// File: hdl/ofa_sqrt_pipe.sv
// Pipelined floor square root, one result bit per register stage.
// Carries a sideband vector alongside; standalone, no package use.
module ofa_sqrt_pipe #(
	parameter int VW = 48,
	parameter int PW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [VW-1:0]     in_val,
	input  logic [PW-1:0]     in_side,
	output logic              out_valid,
	output logic [VW/2-1:0]   out_root,
	output logic [PW-1:0]     out_side
);

	localparam int RW = VW / 2;

	logic [RW+1:0] rem_s  [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [VW-1:0] rest_s [0:RW];
	logic [PW-1:0] side_s [0:RW];
	logic          vld_s  [0:RW];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rest_s[0] = in_val;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+3:0] cur;
		logic [RW+3:0] trial;
		logic          take;

		always_comb begin
			cur   = {rem_s[k], rest_s[k][VW-1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			take  = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (RW+2)'(cur - trial) : (RW+2)'(cur);
				root_s[k+1] <= {root_s[k][RW-2:0], take};
				rest_s[k+1] <= {rest_s[k][VW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

// File: hdl/ofa_div_pipe.sv
// Three-lane pipelined restoring divider with a shared divisor.
// One quotient bit per stage; high numerator part must be below the divisor.
module ofa_div_pipe #(
	parameter int NW = 54,
	parameter int DW = 24,
	parameter int QW = 31,
	parameter int PW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][NW-1:0]   in_num,
	input  logic [DW-1:0]        in_den,
	input  logic [PW-1:0]        in_side,
	output logic                 out_valid,
	output logic [2:0][QW-1:0]   out_quot,
	output logic [PW-1:0]        out_side
);

	logic [2:0][DW-1:0] rem_s  [0:QW];
	logic [2:0][QW-1:0] lq_s   [0:QW];
	logic [DW-1:0]      den_s  [0:QW];
	logic [PW-1:0]      side_s [0:QW];
	logic               vld_s  [0:QW];

	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_s[0][l] = DW'(in_num[l][NW-1:QW]);
		assign lq_s[0][l]  = in_num[l][QW-1:0];
	end
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [2:0][DW:0]   cur;
		logic [2:0]         ge;
		logic [2:0][DW-1:0] rem_nxt;
		logic [2:0][QW-1:0] lq_nxt;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				cur[l]     = {rem_s[k][l], lq_s[k][l][QW-1]};
				ge[l]      = cur[l] >= {1'b0, den_s[k]};
				rem_nxt[l] = ge[l] ? DW'(cur[l] - {1'b0, den_s[k]}) : DW'(cur[l]);
				lq_nxt[l]  = {lq_s[k][l][QW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nxt;
				lq_s[k+1]   <= lq_nxt;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quot  = lq_s[QW];
	assign out_side  = side_s[QW];

endmodule

// File: hdl/orthonormal_frame_from_axis.sv
// Orthonormal frame from one direction vector. Takes one transfer per clock unless
// stalled and returns one frame per transfer in order. The pipeline holds two square
// root pipelines (COMPONENT_WIDTH and 31 stages) and two 31-stage divider pipelines.
// Any output stall freezes the whole pipe.
// Depends on ofa_pkg, ofa_sqrt_pipe, ofa_div_pipe.
module orthonormal_frame_from_axis
	import ofa_pkg::*;
#(
	parameter int COMPONENT_WIDTH = DEFAULT_COMPONENT_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// dir_x, dir_y, dir_z (COMPONENT_WIDTH each), zero pad
	input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// first_x/y/z, second_x/y/z, third_x/y/z (32 each)
	output logic [9*OUT_W-1:0]                    m_tdata,
	// zero_direction
	output logic                                  m_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [APB_ADDR_W-1:0]                 paddr,
	input  logic [APB_DATA_W-1:0]                 pwdata,
	output logic [APB_DATA_W-1:0]                 prdata,
	output logic                                  pready
);

	localparam int W  = COMPONENT_WIDTH;
	localparam int SW = 2 * W;
	localparam int PW1 = 3 * W + 4;
	localparam int TW = 2 * QUOT_BITS;
	localparam int PW2 = 1 + 3 * OUT_W + 3 + 3 * QUOT_BITS;
	localparam int PW3 = 1 + 3 * OUT_W + 3 + 1;

	logic en;
	logic [MIN_NORM_W-1:0] min_norm_q;

	// register port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= '0;
		end else if (psel && penable && pwrite && paddr[3] == REG_MIN_NORM) begin
			min_norm_q <= pwdata[MIN_NORM_W-1:0];
		end
	end
	assign prdata = (paddr[3] == REG_MIN_NORM) ? APB_DATA_W'(min_norm_q) : '0;

	logic out_v_s10;
	assign en       = !out_v_s10 || m_tready;
	assign s_tready = en;

	// s1: magnitudes and squares
	logic [2:0][W-1:0]  dr;
	logic [2:0][W-1:0]  mag;
	logic               v_s1;
	logic [2:0]         sign_s1;
	logic [2:0][W-1:0]  mag_s1;
	logic [2:0][SW-1:0] sq_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dr[i]  = s_tdata[i*W +: W];
			mag[i] = dr[i][W-1] ? W'(~dr[i] + 1'b1) : dr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sign_s1[i] <= dr[i][W-1];
				mag_s1[i]  <= mag[i];
				sq_s1[i]   <= {{W{1'b0}}, mag[i]} * {{W{1'b0}}, mag[i]};
			end
		end
	end

	// s2: squared norm and rejection
	logic              v_s2;
	logic [SW-1:0]     sum_s2;
	logic              rej_s2;
	logic [2:0]        sign_s2;
	logic [2:0][W-1:0] mag_s2;
	logic [SW-1:0]     sum_c;

	assign sum_c = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_c;
			rej_s2  <= 64'(sum_c) <= 64'(min_norm_q);
			sign_s2 <= sign_s1;
			mag_s2  <= mag_s1;
		end
	end

	// norm
	logic              sq1_v;
	logic [W-1:0]      norm;
	logic [PW1-1:0]    sq1_side;
	logic              sq1_rej;
	logic [2:0]        sq1_sign;
	logic [2:0][W-1:0] sq1_mag;

	ofa_sqrt_pipe #(.VW(SW), .PW(PW1)) u_norm_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_val    (sum_s2),
		.in_side   ({rej_s2, sign_s2, mag_s2}),
		.out_valid (sq1_v),
		.out_root  (norm),
		.out_side  (sq1_side)
	);
	assign {sq1_rej, sq1_sign, sq1_mag} = sq1_side;

	// first = d / norm
	logic [2:0][W+FRAC_BITS-1:0] num1;
	logic                        dv1_v;
	logic [2:0][QUOT_BITS-1:0]   q1;
	logic [3:0]                  dv1_side;
	logic                        dv1_rej;
	logic [2:0]                  dv1_sign;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num1[i] = {sq1_mag[i], {FRAC_BITS{1'b0}}};
		end
	end

	ofa_div_pipe #(.NW(W + FRAC_BITS), .DW(W), .QW(QUOT_BITS), .PW(4)) u_first_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq1_v),
		.in_num    (num1),
		.in_den    (norm),
		.in_side   ({sq1_rej, sq1_sign}),
		.out_valid (dv1_v),
		.out_quot  (q1),
		.out_side  (dv1_side)
	);
	assign {dv1_rej, dv1_sign} = dv1_side;

	// s3: signed first, least aligned axis
	logic                      v_s3;
	logic                      rej_s3;
	logic [2:0][OUT_W-1:0]     f_s3;
	logic [2:0][QUOT_BITS-1:0] fmag_s3;
	logic [2:0]                fsign_s3;
	axis_t                     axis_s3;
	logic [QUOT_BITS-1:0]      famag_s3;
	logic                      fasign_s3;
	axis_t                     axis_c;
	logic [QUOT_BITS-1:0]      min_c;
	logic                      asign_c;

	always_comb begin
		axis_c  = AXIS_X;
		min_c   = q1[0];
		asign_c = dv1_sign[0];
		if (q1[1] < min_c) begin
			axis_c  = AXIS_Y;
			min_c   = q1[1];
			asign_c = dv1_sign[1];
		end
		if (q1[2] < min_c) begin
			axis_c  = AXIS_Z;
			min_c   = q1[2];
			asign_c = dv1_sign[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s3 <= dv1_rej;
			for (int i = 0; i < 3; i++) begin
				f_s3[i] <= dv1_sign[i] ? OUT_W'(-{1'b0, q1[i]}) : {1'b0, q1[i]};
			end
			fmag_s3   <= q1;
			fsign_s3  <= dv1_sign;
			axis_s3   <= axis_c;
			famag_s3  <= min_c;
			fasign_s3 <= asign_c;
		end
	end

	// s4: projection products
	logic               v_s4;
	logic               rej_s4;
	logic [2:0][OUT_W-1:0] f_s4;
	axis_t              axis_s4;
	logic [2:0][TW-1:0] prod_s4;
	logic [2:0]         psign_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s4  <= rej_s3;
			f_s4    <= f_s3;
			axis_s4 <= axis_s3;
			for (int i = 0; i < 3; i++) begin
				prod_s4[i]  <= {{QUOT_BITS{1'b0}}, famag_s3} *
					{{QUOT_BITS{1'b0}}, fmag_s3[i]};
				psign_s4[i] <= fasign_s3 ^ fsign_s3[i];
			end
		end
	end

	// s5: u = axis - projection
	logic                      v_s5;
	logic                      rej_s5;
	logic [2:0][OUT_W-1:0]     f_s5;
	logic [2:0][QUOT_BITS-1:0] umag_s5;
	logic [2:0]                usign_s5;
	logic [2:0][OUT_W-1:0]     tr_c;
	logic [2:0][OUT_W-1:0]     term_c;
	logic [2:0][OUT_W-1:0]     u_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tr_c[i]   = prod_s4[i][TW-1:FRAC_BITS];
			term_c[i] = psign_s4[i] ? OUT_W'(-tr_c[i]) : tr_c[i];
			u_c[i]    = ((axis_s4 == AXIS_X && i == 0) || (axis_s4 == AXIS_Y && i == 1) ||
				(axis_s4 == AXIS_Z && i == 2)) ? OUT_W'(ONE_Q30 - term_c[i]) :
				OUT_W'(-term_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s5 <= rej_s4;
			f_s5   <= f_s4;
			for (int i = 0; i < 3; i++) begin
				usign_s5[i] <= u_c[i][OUT_W-1];
				umag_s5[i]  <= u_c[i][OUT_W-1] ? QUOT_BITS'(-u_c[i]) : u_c[i][QUOT_BITS-1:0];
			end
		end
	end

	// s6: squares of u
	logic                      v_s6;
	logic                      rej_s6;
	logic [2:0][OUT_W-1:0]     f_s6;
	logic [2:0][QUOT_BITS-1:0] umag_s6;
	logic [2:0]                usign_s6;
	logic [2:0][TW-1:0]        usq_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s6   <= rej_s5;
			f_s6     <= f_s5;
			umag_s6  <= umag_s5;
			usign_s6 <= usign_s5;
			for (int i = 0; i < 3; i++) begin
				usq_s6[i] <= {{QUOT_BITS{1'b0}}, umag_s5[i]} *
					{{QUOT_BITS{1'b0}}, umag_s5[i]};
			end
		end
	end

	// s7: length of u squared
	logic                      v_s7;
	logic [TW-1:0]             tsum_s7;
	logic [PW2-1:0]            side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tsum_s7 <= usq_s6[0] + usq_s6[1] + usq_s6[2];
			side_s7 <= {rej_s6, f_s6, usign_s6, umag_s6};
		end
	end

	logic                      sq2_v;
	logic [QUOT_BITS-1:0]      unorm;
	logic [PW2-1:0]            sq2_side;
	logic                      sq2_rej;
	logic [2:0][OUT_W-1:0]     sq2_f;
	logic [2:0]                sq2_usign;
	logic [2:0][QUOT_BITS-1:0] sq2_umag;

	ofa_sqrt_pipe #(.VW(TW), .PW(PW2)) u_aux_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_val    (tsum_s7),
		.in_side   (side_s7),
		.out_valid (sq2_v),
		.out_root  (unorm),
		.out_side  (sq2_side)
	);
	assign {sq2_rej, sq2_f, sq2_usign, sq2_umag} = sq2_side;

	// second = u / |u|
	logic [2:0][QUOT_BITS+FRAC_BITS-1:0] num2;
	logic                                dv2_v;
	logic [2:0][QUOT_BITS-1:0]           q2;
	logic [PW3-1:0]                      dv2_side;
	logic                                dv2_rej;
	logic [2:0][OUT_W-1:0]               dv2_f;
	logic [2:0]                          dv2_usign;
	logic                                dv2_mzero;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num2[i] = {sq2_umag[i], {FRAC_BITS{1'b0}}};
		end
	end

	ofa_div_pipe #(.NW(QUOT_BITS + FRAC_BITS), .DW(QUOT_BITS), .QW(QUOT_BITS), .PW(PW3))
	u_second_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq2_v),
		.in_num    (num2),
		.in_den    (unorm),
		.in_side   ({sq2_rej, sq2_f, sq2_usign, unorm == '0}),
		.out_valid (dv2_v),
		.out_quot  (q2),
		.out_side  (dv2_side)
	);
	assign {dv2_rej, dv2_f, dv2_usign, dv2_mzero} = dv2_side;

	// s8: signed second
	logic                  v_s8;
	logic                  rej_s8;
	logic [2:0][OUT_W-1:0] f_s8;
	logic [2:0][OUT_W-1:0] s_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s8 <= dv2_rej;
			f_s8   <= dv2_f;
			for (int i = 0; i < 3; i++) begin
				if (dv2_mzero) begin
					s_s8[i] <= '0;
				end else begin
					s_s8[i] <= dv2_usign[i] ? OUT_W'(-{1'b0, q2[i]}) : {1'b0, q2[i]};
				end
			end
		end
	end

	// s9: cross product terms, order (a, b) per component: x, y, z
	logic                  v_s9;
	logic                  rej_s9;
	logic [2:0][OUT_W-1:0] f_s9;
	logic [2:0][OUT_W-1:0] s_s9;
	logic [5:0][TW-1:0]    cp_s9;
	logic signed [OUT_W-1:0]   ma [6];
	logic signed [OUT_W-1:0]   mb [6];
	logic signed [2*OUT_W-1:0] mp [6];

	always_comb begin
		ma[0] = f_s8[1]; mb[0] = s_s8[2];
		ma[1] = f_s8[2]; mb[1] = s_s8[1];
		ma[2] = f_s8[2]; mb[2] = s_s8[0];
		ma[3] = f_s8[0]; mb[3] = s_s8[2];
		ma[4] = f_s8[0]; mb[4] = s_s8[1];
		ma[5] = f_s8[1]; mb[5] = s_s8[0];
		for (int k = 0; k < 6; k++) begin
			mp[k] = ma[k] * mb[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s9 <= rej_s8;
			f_s9   <= f_s8;
			s_s9   <= s_s8;
			for (int k = 0; k < 6; k++) begin
				cp_s9[k] <= mp[k][TW-1:0];
			end
		end
	end

	// s10: difference, truncate, saturate; output register
	logic [2:0][TW:0]      diff_c;
	logic [2:0][TW:0]      dmag_c;
	logic [2:0][TW-FRAC_BITS:0] sh_c;
	logic [2:0][OUT_W-1:0] sat_c;
	logic [2:0][OUT_W-1:0] t_c;
	logic [9*OUT_W-1:0]    data_s10;
	logic                  zero_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = {cp_s9[2*i][TW-1], cp_s9[2*i]} - {cp_s9[2*i+1][TW-1], cp_s9[2*i+1]};
			dmag_c[i] = diff_c[i][TW] ? (TW+1)'(-diff_c[i]) : diff_c[i];
			sh_c[i]   = dmag_c[i][TW:FRAC_BITS];
			sat_c[i]  = (sh_c[i] > (TW-FRAC_BITS+1)'(ONE_Q30)) ? ONE_Q30 :
				sh_c[i][OUT_W-1:0];
			t_c[i]    = diff_c[i][TW] ? OUT_W'(-sat_c[i]) : sat_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s10 <= 1'b0;
		end else if (en) begin
			out_v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s10 <= rej_s9;
			data_s10 <= rej_s9 ? '0 : {t_c, s_s9, f_s9};
		end
	end

	assign m_tvalid = out_v_s10;
	assign m_tdata  = data_s10;
	assign m_tuser  = zero_s10;

endmodule
